// File: hw/rtl/sld_pkg.sv
package sld_pkg;

    // Default build values
    localparam int SAMPLES_PER_PACKET_DEF = 12;
    localparam int DEPTH_BITS_DEF         = 16;
    localparam int FRAC_BITS_DEF          = 16;

    // Fixed field widths
    localparam int IN_W      = 16;
    localparam int RATE_W    = 20;
    localparam int ALPHA_W   = 17;
    localparam int NS_W      = 37;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

    // Register reset values
    localparam logic [RATE_W-1:0]  RATE_RST   = 20'd48000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd8192;
    localparam logic [NS_W-1:0]    THRESH_RST = 37'd500000;

    // Alpha is Q1.16; 1.0 is the largest weight that takes effect
    localparam int                 ALPHA_Q    = 16;
    localparam int                 ROUND_HALF = 1 << (ALPHA_Q - 1);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;

    localparam longint unsigned NS_PER_S = 64'd1000000000;

    typedef logic [NS_W-1:0] t_ns;

    localparam t_ns NS_MAX = '1;

endpackage

// File: hw/rtl/smoothed_latency_change_detector_core.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+--------------------------------------
// in       | to core   | i_in_valid / o_in_stall  | i_depth_frames[15:0]
// out      | from core | o_out_valid / i_out_stall| o_latency_ns[36:0], o_material_change
// cfg      | to core   | i_cfg_we                 | i_cfg_index[1:0], i_cfg_data[36:0]
//
// One transaction is processed at a time. A poll runs through the smoothing step (the
// seeding poll just loads the depth), the bit-serial multiply by SAMPLES_PER_PACKET*1e9,
// the bit-serial divider, which is the longest step, then a finish step and a return to
// idle, where the next poll can be accepted.
// Reset is synchronous, active low; it restores the register defaults and clears the
// smoothed depth, the seeded flag and the advertised baseline.
// A stalled result sits in the output register; the next input transaction is taken
// meanwhile and only its finish step waits for the register to drain.
module smoothed_latency_change_detector_core #(
    parameter int SAMPLES_PER_PACKET = sld_pkg::SAMPLES_PER_PACKET_DEF,
    parameter int DEPTH_BITS         = sld_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS          = sld_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transactions
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sld_pkg::IN_W-1:0]        i_depth_frames,
    // result transactions
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sld_pkg::NS_W-1:0]        o_latency_ns,
    output logic                            o_material_change,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sld_pkg::NS_W-1:0]        i_cfg_data
);
    import sld_pkg::*;

    // Smoothed depth is unsigned Q(DEPTH_BITS).(FRAC_BITS).
    localparam int SD_W = DEPTH_BITS + FRAC_BITS;
    // Multiplicand is one plus the smoothed depth, in the same format.
    localparam int XW   = SD_W + 1;
    localparam longint unsigned KMUL = longint'(SAMPLES_PER_PACKET) * NS_PER_S;
    localparam int K_W  = $clog2(KMUL + 1);
    localparam int PW   = XW + K_W;
    // Numerator 2*N + D for round-half-up, divisor 2*D, D = rate << FRAC_BITS.
    localparam int N2W  = PW + 2;
    localparam int DEN_W = RATE_W + FRAC_BITS;
    localparam int DVW  = DEN_W + 1;
    localparam int IW   = (DEPTH_BITS > IN_W) ? DEPTH_BITS : IN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EMA  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [RATE_W-1:0]  r_rate;
    logic [ALPHA_W-1:0] r_alpha;
    t_ns                r_thresh;
    t_ns                r_adv, n_adv;
    logic               r_out_valid, n_out_valid;
    t_ns                r_ns_out, n_ns_out;
    logic               r_mat_out, n_mat_out;

    logic               in_accept;
    logic               slot_free;
    logic               fin_load;

    logic [IW-1:0]         depth_ext;
    logic [IW-1:0]         depth_max;
    logic [DEPTH_BITS-1:0] depth_sat;

    logic               ema_done;
    logic [SD_W-1:0]    ema_sd;
    logic               mul_start;
    logic [XW-1:0]      mul_x;
    logic               mul_done;
    logic [PW-1:0]      mul_prod;
    logic               div_start;
    logic [N2W-1:0]     div_num;
    logic [DVW-1:0]     div_den;
    logic               div_done;
    t_ns                div_q;
    logic               div_ovf;

    t_ns                lat;
    t_ns                diff;
    logic               material;

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign fin_load  = (r_state == ST_FIN) && slot_free;

    // Clip the observed depth to what the integer part can hold.
    always_comb begin
        depth_ext = IW'(i_depth_frames);
        depth_max = IW'((1 << DEPTH_BITS) - 1);
        depth_sat = (depth_ext > depth_max) ? DEPTH_BITS'(depth_max)
                                            : DEPTH_BITS'(depth_ext);
    end

    sld_ema #(
        .DEPTH_BITS (DEPTH_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_depth (depth_sat),
        .i_alpha (r_alpha),
        .o_done  (ema_done),
        .o_sd    (ema_sd)
    );

    assign mul_start = (r_state == ST_EMA) && ema_done;
    assign mul_x     = XW'(ema_sd) + (XW'(1) << FRAC_BITS);

    sld_cmul #(
        .XW   (XW),
        .PW   (PW),
        .KMUL (KMUL)
    ) u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // floor((2N + D) / 2D) rounds N/D to nearest with ties upward.
    assign div_start = (r_state == ST_MUL) && mul_done;
    assign div_num   = N2W'({mul_prod, 1'b0}) + N2W'({r_rate, {FRAC_BITS{1'b0}}});
    assign div_den   = {r_rate, {(FRAC_BITS + 1){1'b0}}};

    sld_div #(
        .NW (N2W),
        .DW (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_ovf   (div_ovf)
    );

    // Finish: saturate, force zero latency at zero rate, then test the baseline.
    always_comb begin
        if (r_rate == '0) begin
            lat = '0;
        end else if (div_ovf) begin
            lat = NS_MAX;
        end else begin
            lat = div_q;
        end
        diff     = (lat >= r_adv) ? (lat - r_adv) : (r_adv - lat);
        // nothing advertised yet counts as a change
        material = (r_adv == '0) || (diff >= r_thresh);
    end

    always_comb begin
        n_state     = r_state;
        n_adv       = r_adv;
        n_out_valid = r_out_valid;
        n_ns_out    = r_ns_out;
        n_mat_out   = r_mat_out;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EMA;
                end
            end
            ST_EMA: begin
                if (ema_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold here until the output register is free
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_ns_out    = lat;
                    n_mat_out   = material;
                    if (material) begin
                        n_adv = lat;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_adv       <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= RATE_RST;
            r_alpha     <= ALPHA_RST;
            r_thresh    <= THRESH_RST;
        end else begin
            r_state     <= n_state;
            r_adv       <= n_adv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                    CFG_THRESH: r_thresh <= i_cfg_data[NS_W-1:0];
                    default: begin
                        // unused index: ignore the write
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns_out  <= n_ns_out;
        r_mat_out <= n_mat_out;
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_latency_ns      = r_ns_out;
    assign o_material_change = r_mat_out;

    // A new result appears only from the finish step.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result valid raised outside the finish step");

    // An accepted poll always starts the smoothing step.
    a_accept_to_ema: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_EMA))
        else $error("accepted poll did not enter the smoothing step");

    // The divider finishes only while the sequencer waits for it.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside the divide step");

    // With no baseline stored, the result must report a change.
    a_first_material: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_load && (r_adv == '0)) |=> o_material_change)
        else $error("empty baseline did not flag a change");

endmodule

// File: hw/rtl/sld_ema.sv
module sld_ema #(
    parameter int DEPTH_BITS = sld_pkg::DEPTH_BITS_DEF,
    parameter int FRAC_BITS  = sld_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DEPTH_BITS-1:0]          i_depth,
    input  logic [sld_pkg::ALPHA_W-1:0]    i_alpha,
    output logic                           o_done,
    output logic [DEPTH_BITS+FRAC_BITS-1:0] o_sd
);
    import sld_pkg::*;

    localparam int SD_W = DEPTH_BITS + FRAC_BITS;
    localparam int AW   = SD_W + ALPHA_W;
    localparam int CW   = $clog2(ALPHA_W + 1);

    logic [SD_W-1:0]    r_sd, n_sd;
    logic               r_seeded, n_seeded;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [SD_W-1:0]    r_mag, n_mag;
    logic [ALPHA_W-1:0] r_a, n_a;
    logic [AW-1:0]      r_acc, n_acc;
    logic               r_up, n_up;

    logic [SD_W-1:0]    target;
    logic [ALPHA_W-1:0] a_clamp;
    logic [AW-1:0]      acc_step;
    logic [AW-1:0]      rounded;
    logic [SD_W-1:0]    step;

    always_comb begin
        target   = {i_depth, {FRAC_BITS{1'b0}}};
        a_clamp  = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
        // one alpha bit per cycle, MSB first
        acc_step = {r_acc[AW-2:0], 1'b0} + (r_a[ALPHA_W-1] ? AW'(r_mag) : '0);
        rounded  = r_acc + AW'(ROUND_HALF);
        step     = SD_W'(rounded >> ALPHA_Q);

        n_sd     = r_sd;
        n_seeded = r_seeded;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mag    = r_mag;
        n_a      = r_a;
        n_acc    = r_acc;
        n_up     = r_up;

        if (i_start) begin
            if (!r_seeded) begin
                n_sd     = target;
                n_seeded = 1'b1;
                n_done   = 1'b1;
            end else begin
                n_up   = (target >= r_sd);
                n_mag  = (target >= r_sd) ? (target - r_sd) : (r_sd - target);
                n_a    = a_clamp;
                n_acc  = '0;
                n_cnt  = CW'(ALPHA_W);
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_acc = acc_step;
                n_a   = {r_a[ALPHA_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end else begin
                // step never exceeds the distance, so the target is never passed
                n_sd   = r_up ? (r_sd + step) : (r_sd - step);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd     <= '0;
            r_seeded <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_sd     <= n_sd;
            r_seeded <= n_seeded;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_a   <= n_a;
        r_acc <= n_acc;
        r_up  <= n_up;
    end

    assign o_done = r_done;
    assign o_sd   = r_sd;

endmodule

// File: hw/rtl/sld_cmul.sv
module sld_cmul #(
    parameter int              XW   = sld_pkg::DEPTH_BITS_DEF + sld_pkg::FRAC_BITS_DEF + 1,
    parameter int              PW   = XW + 34,
    parameter longint unsigned KMUL = 64'd12000000000
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [XW-1:0] i_x,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);
    import sld_pkg::*;

    localparam int CW = $clog2(XW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [XW-1:0] r_x, n_x;
    logic [PW-1:0] r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_acc  = r_acc;
        if (i_start) begin
            n_x    = i_x;
            n_acc  = '0;
            n_cnt  = CW'(XW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                // shift in one multiplicand bit, MSB first
                n_acc = {r_acc[PW-2:0], 1'b0} + (r_x[XW-1] ? PW'(KMUL) : '0);
                n_x   = {r_x[XW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: hw/rtl/sld_div.sv
module sld_div #(
    parameter int NW = 69,
    parameter int DW = sld_pkg::RATE_W + sld_pkg::FRAC_BITS_DEF + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    output logic               o_done,
    output sld_pkg::t_ns       o_quo,
    output logic               o_ovf
);
    import sld_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_num, n_num;
    logic [DW-1:0] r_den, n_den;
    logic [DW-1:0] r_rem, n_rem;
    t_ns           r_q, n_q;
    logic          r_ovf, n_ovf;

    logic [DW:0]   trial;
    logic [DW:0]   diffv;
    logic          ge;

    always_comb begin
        // bring down one numerator bit and try the subtract
        trial = {r_rem, r_num[NW-1]};
        diffv = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_q    = '0;
            n_ovf  = 1'b0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_rem = ge ? diffv[DW-1:0] : trial[DW-1:0];
                n_num = {r_num[NW-2:0], 1'b0};
                n_q   = {r_q[NS_W-2:0], ge};
                // a one leaving the top of the quotient means it will not fit
                n_ovf = r_ovf | r_q[NS_W-1];
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

endmodule
